### hdl/bfpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfpa_pkg
// Shared types and codes for the best-fit page allocator.
// ----------------------------------------------------------------------------
package bfpa_pkg;

    // One entry of the segment table
    typedef struct packed {
        logic [11:0] start;
        logic [12:0] len;
        logic        used;
    } t_seg;

    // Request kinds
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BAD    = 2'd1;
    localparam logic [1:0] ST_NOROOM = 2'd2;

    // Reset value of the area limit register
    localparam logic [12:0] LIMIT_RESET = 13'd4096;

endpackage
`default_nettype wire

### hdl/bfpa_seg_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfpa_seg_ram
// Segment table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bfpa_seg_ram #(
    parameter int DEPTH = 32,
    parameter int IDX_W = 5
) (
    input  wire                  i_clk,
    input  wire                  i_we,
    input  wire [IDX_W-1:0]      i_waddr,
    input  wire bfpa_pkg::t_seg  i_wdata,
    input  wire                  i_re,
    input  wire [IDX_W-1:0]      i_raddr,
    output bfpa_pkg::t_seg       o_rdata
);

    bfpa_pkg::t_seg r_mem [DEPTH];
    bfpa_pkg::t_seg r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### hdl/best_fit_page_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// A request scans the table when it is not empty and then decides; a split or a merge that
// moves entries shifts the table before the final writes. The table holds at most MAX_SEGMENTS.
// Throughput: one request at a time; the single read port of the segment table sets the
// pace of both the scan and the shift. The result register lets the next request in while
// a result waits. Reset (synchronous, active low) empties the table, sets the area end to 0
// and the limit to 4096; the table memory needs no clearing pass.
// ----------------------------------------------------------------------------
// best_fit_page_allocator
// Best-fit page allocator with coalescing over one growable page area.
// ----------------------------------------------------------------------------
module best_fit_page_allocator #(
    parameter int MAX_SEGMENTS = 32,
    parameter int AREA_PAGES   = 4096
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // request stream
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire [31:0]  i_s_axis_tdata,   // [12:0] pages, [24:13] block_page
    input  wire         i_s_axis_tuser,   // [0] req_type
    // result stream
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [1:0] status, [13:2] granted_page, [26:14] end_page
    // limit register write
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire [12:0]  i_cfg_data        // area_limit_pages
);

    localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SEGMENTS);
    localparam logic [12:0] AREA_CAP = (AREA_PAGES > 4096) ? 13'd4096 : 13'(AREA_PAGES);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_WR1    = 3'd4;
    localparam logic [2:0] S_WR2    = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]       r_state;
    logic [12:0]      r_limit;
    logic [CNT_W-1:0] r_total;
    logic [12:0]      r_area_end;

    // request
    logic        r_req;
    logic [12:0] r_count;
    logic [11:0] r_page;

    // scan results
    logic [IDX_W-1:0] r_addr;
    logic             r_hit_found;
    logic [IDX_W-1:0] r_hit_idx;
    bfpa_pkg::t_seg   r_hit_ent;
    logic             r_bs_found;
    logic [IDX_W-1:0] r_bs_idx;
    bfpa_pkg::t_seg   r_bs_ent;
    bfpa_pkg::t_seg   r_prev;
    bfpa_pkg::t_seg   r_p_ent;
    bfpa_pkg::t_seg   r_n_ent;
    logic             r_n_want;

    // shift engine
    logic [IDX_W-1:0] r_src;
    logic [IDX_W-1:0] r_src_end;
    logic             r_dir_left;
    logic [1:0]       r_dist;
    logic             r_rd_done;
    logic             r_pend;
    logic [IDX_W-1:0] r_pend_dst;

    // final writes
    logic [IDX_W-1:0] r_w1_addr;
    bfpa_pkg::t_seg   r_w1_data;
    logic             r_w2_en;
    logic [IDX_W-1:0] r_w2_addr;
    bfpa_pkg::t_seg   r_w2_data;

    // result
    logic [1:0]  r_status;
    logic [11:0] r_granted;
    logic        r_out_valid;
    logic [31:0] r_out_data;

    // memory ports
    logic             w_we;
    logic [IDX_W-1:0] w_waddr;
    bfpa_pkg::t_seg   w_wdata;
    logic             w_re;
    logic [IDX_W-1:0] w_raddr;
    bfpa_pkg::t_seg   w_rd;

    logic             w_in_xfer;
    logic [IDX_W-1:0] w_last_idx;
    logic [12:0]      w_eff;
    logic [13:0]      w_grow_end;
    logic [13:0]      w_app_end;
    logic             w_p;
    logic             w_n;
    logic [IDX_W-1:0] w_m_idx;
    logic [11:0]      w_m_start;
    logic [12:0]      w_m_len;
    logic [1:0]       w_r;
    logic [CNT_W-1:0] w_after;
    logic [IDX_W-1:0] w_dst;

    assign w_in_xfer       = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    assign w_last_idx = IDX_W'(r_total - 1'b1);
    assign w_eff      = (r_limit > AREA_CAP) ? AREA_CAP : r_limit;
    assign w_grow_end = {1'b0, r_area_end} + {1'b0, r_count} - {1'b0, r_prev.len};
    assign w_app_end  = {1'b0, r_area_end} + {1'b0, r_count};

    // Merge terms for a free
    assign w_p       = (r_hit_idx != '0) && !r_p_ent.used;
    assign w_n       = ((CNT_W'(r_hit_idx) + 1'b1) < r_total) && !r_n_ent.used;
    assign w_m_idx   = w_p ? (r_hit_idx - 1'b1) : r_hit_idx;
    assign w_m_start = w_p ? r_p_ent.start : r_hit_ent.start;
    assign w_m_len   = (w_p ? r_p_ent.len : 13'd0) + r_hit_ent.len
                     + (w_n ? r_n_ent.len : 13'd0);
    assign w_r       = {w_p & w_n, w_p ^ w_n};
    assign w_after   = CNT_W'(r_hit_idx) + CNT_W'(w_n) + 1'b1;
    assign w_dst     = r_dir_left ? (r_src - IDX_W'(r_dist)) : (r_src + 1'b1);

    bfpa_seg_ram #(
        .DEPTH (MAX_SEGMENTS),
        .IDX_W (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rd)
    );

    // Read port select
    always_comb begin
        w_re    = 1'b0;
        w_raddr = r_addr + 1'b1;
        case (r_state)
            S_IDLE: begin
                w_re    = w_in_xfer && (r_total != '0);
                w_raddr = '0;
            end
            S_SCAN: begin
                w_re    = (r_addr != w_last_idx);
                w_raddr = r_addr + 1'b1;
            end
            S_SHIFT: begin
                w_re    = !r_rd_done;
                w_raddr = r_src;
            end
            default: begin
                w_re = 1'b0;
            end
        endcase
    end

    // Write port select
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_w1_addr;
        w_wdata = r_w1_data;
        case (r_state)
            S_SHIFT: begin
                w_we    = r_pend;
                w_waddr = r_pend_dst;
                w_wdata = w_rd;
            end
            S_WR1: begin
                w_we = 1'b1;
            end
            S_WR2: begin
                w_we    = 1'b1;
                w_waddr = r_w2_addr;
                w_wdata = r_w2_data;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    // Limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= bfpa_pkg::LIMIT_RESET;
        end else if (i_cfg_valid) begin
            r_limit <= i_cfg_data;
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_total     <= '0;
            r_area_end  <= '0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
            r_rd_done   <= 1'b0;
            r_n_want    <= 1'b0;
            r_hit_found <= 1'b0;
            r_bs_found  <= 1'b0;
            r_w2_en     <= 1'b0;
        end else begin
            // drop the result once transferred, unless a new one replaces it
            if (r_out_valid && i_m_axis_tready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                // take a request and start the scan
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_req       <= i_s_axis_tuser;
                        r_count     <= i_s_axis_tdata[12:0];
                        r_page      <= i_s_axis_tdata[24:13];
                        r_addr      <= '0;
                        r_hit_found <= 1'b0;
                        r_bs_found  <= 1'b0;
                        r_n_want    <= 1'b0;
                        r_w2_en     <= 1'b0;
                        r_granted   <= '0;
                        r_state     <= (r_total != '0) ? S_SCAN : S_DECIDE;
                    end
                end
                // examine one entry per cycle
                S_SCAN: begin
                    r_prev <= w_rd;
                    if (r_n_want) begin
                        r_n_ent  <= w_rd;
                        r_n_want <= 1'b0;
                    end
                    if (r_req == bfpa_pkg::REQ_ALLOC) begin
                        if (!r_hit_found && !w_rd.used && (w_rd.len == r_count)) begin
                            r_hit_found <= 1'b1;
                            r_hit_idx   <= r_addr;
                            r_hit_ent   <= w_rd;
                        end
                        if (!w_rd.used && (r_count < w_rd.len)
                            && (!r_bs_found || (w_rd.len < r_bs_ent.len))) begin
                            r_bs_found <= 1'b1;
                            r_bs_idx   <= r_addr;
                            r_bs_ent   <= w_rd;
                        end
                    end else begin
                        if (!r_hit_found && (w_rd.start == r_page)) begin
                            r_hit_found <= 1'b1;
                            r_hit_idx   <= r_addr;
                            r_hit_ent   <= w_rd;
                            r_p_ent     <= r_prev;
                            r_n_want    <= 1'b1;
                        end
                    end
                    if (r_addr == w_last_idx) begin
                        r_state <= S_DECIDE;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                // choose the action and set up the table updates
                S_DECIDE: begin
                    r_status  <= bfpa_pkg::ST_OK;
                    r_rd_done <= 1'b0;
                    r_pend    <= 1'b0;
                    r_state   <= S_WR1;
                    if (r_req == bfpa_pkg::REQ_ALLOC) begin
                        if (r_count == '0) begin
                            r_status <= bfpa_pkg::ST_BAD;
                            r_state  <= S_DONE;
                        end else if (r_hit_found) begin
                            r_w1_addr <= r_hit_idx;
                            r_w1_data <= '{start: r_hit_ent.start, len: r_hit_ent.len,
                                           used: 1'b1};
                            r_granted <= r_hit_ent.start;
                        end else if (r_bs_found) begin
                            if (r_total >= MAX_CNT) begin
                                r_status <= bfpa_pkg::ST_NOROOM;
                                r_state  <= S_DONE;
                            end else begin
                                r_w1_addr <= r_bs_idx;
                                r_w1_data <= '{start: r_bs_ent.start, len: r_count,
                                               used: 1'b1};
                                r_w2_en   <= 1'b1;
                                r_w2_addr <= r_bs_idx + 1'b1;
                                r_w2_data <= '{start: r_bs_ent.start + r_count[11:0],
                                               len: r_bs_ent.len - r_count, used: 1'b0};
                                r_granted <= r_bs_ent.start;
                                r_total   <= r_total + 1'b1;
                                r_src      <= w_last_idx;
                                r_src_end  <= r_bs_idx + 1'b1;
                                r_dir_left <= 1'b0;
                                r_dist     <= 2'd1;
                                if ((CNT_W'(r_bs_idx) + 1'b1) < r_total) begin
                                    r_state <= S_SHIFT;
                                end
                            end
                        end else if ((r_total != '0) && !r_prev.used) begin
                            if (w_grow_end > {1'b0, w_eff}) begin
                                r_status <= bfpa_pkg::ST_NOROOM;
                                r_state  <= S_DONE;
                            end else begin
                                r_w1_addr  <= w_last_idx;
                                r_w1_data  <= '{start: r_prev.start, len: r_count, used: 1'b1};
                                r_granted  <= r_prev.start;
                                r_area_end <= w_grow_end[12:0];
                            end
                        end else begin
                            if ((r_total >= MAX_CNT) || (w_app_end > {1'b0, w_eff})) begin
                                r_status <= bfpa_pkg::ST_NOROOM;
                                r_state  <= S_DONE;
                            end else begin
                                r_w1_addr  <= IDX_W'(r_total);
                                r_w1_data  <= '{start: r_area_end[11:0], len: r_count,
                                                used: 1'b1};
                                r_granted  <= r_area_end[11:0];
                                r_area_end <= w_app_end[12:0];
                                r_total    <= r_total + 1'b1;
                            end
                        end
                    end else begin
                        if (!r_hit_found) begin
                            r_status <= bfpa_pkg::ST_BAD;
                            r_state  <= S_DONE;
                        end else if (w_after == r_total) begin
                            // merged segment ends the area: prune it
                            r_total    <= r_total - CNT_W'(w_r) - 1'b1;
                            r_area_end <= {1'b0, w_m_start};
                            r_state    <= S_DONE;
                        end else begin
                            r_w1_addr  <= w_m_idx;
                            r_w1_data  <= '{start: w_m_start, len: w_m_len, used: 1'b0};
                            r_total    <= r_total - CNT_W'(w_r);
                            r_src      <= IDX_W'(w_after);
                            r_src_end  <= w_last_idx;
                            r_dir_left <= 1'b1;
                            r_dist     <= w_r;
                            if (w_r != 2'd0) begin
                                r_state <= S_SHIFT;
                            end
                        end
                    end
                end
                // move entries one per cycle, read and write overlapped
                S_SHIFT: begin
                    if (!r_rd_done) begin
                        r_pend     <= 1'b1;
                        r_pend_dst <= w_dst;
                        if (r_src == r_src_end) begin
                            r_rd_done <= 1'b1;
                        end else if (r_dir_left) begin
                            r_src <= r_src + 1'b1;
                        end else begin
                            r_src <= r_src - 1'b1;
                        end
                    end else begin
                        r_pend  <= 1'b0;
                        r_state <= S_WR1;
                    end
                end
                S_WR1: begin
                    r_state <= r_w2_en ? S_WR2 : S_DONE;
                end
                S_WR2: begin
                    r_state <= S_DONE;
                end
                // hand the result to the output register
                S_DONE: begin
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {5'd0, r_area_end,
                                        (r_status == bfpa_pkg::ST_OK) ? r_granted : 12'd0,
                                        r_status};
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire
